// ===== rtl/ripple_height_field_stencil_core_assert.svh =====
// Assertion helpers; the enclosing module must provide clk and rst.
`ifndef RIPPLE_HEIGHT_FIELD_STENCIL_CORE_ASSERT_SVH
`define RIPPLE_HEIGHT_FIELD_STENCIL_CORE_ASSERT_SVH

// Same-cycle implication.
`define RHFS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define RHFS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/rhfs_pkg.sv =====
package rhfs_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_HEIGHT  = 1024;
  localparam int DEF_HEIGHT_BITS = 16;

  localparam int CFG_BITS   = 11;
  localparam int SHIFT_BITS = 4;
  localparam int IDX_BITS   = 20;
  localparam int MIN_DIM    = 3;
  localparam int QUEUE_DEPTH = 4;

  // Stencil shifts
  localparam int RIPPLE_SHIFT = 2;
  localparam int SMOOTH_SHIFT = 3;

  typedef enum logic [1:0] {
    REG_FIELD_WIDTH   = 2'd0,
    REG_FIELD_HEIGHT  = 2'd1,
    REG_DAMPING_SHIFT = 2'd2,
    REG_UPDATE_MODE   = 2'd3
  } reg_index_t;

  typedef enum logic {
    MODE_RIPPLE = 1'b0,
    MODE_SMOOTH = 1'b1
  } update_mode_t;

  localparam logic [CFG_BITS-1:0]   RST_FIELD_WIDTH   = 11'd256;
  localparam logic [CFG_BITS-1:0]   RST_FIELD_HEIGHT  = 11'd256;
  localparam logic [SHIFT_BITS-1:0] RST_DAMPING_SHIFT = 4'd2;

  typedef struct packed {
    logic has_int;   // completes the interior cell up-left of this one
    logic has_bord;  // this cell is on the border
  } flags_t;

  typedef struct packed {
    update_mode_t            mode;
    logic [SHIFT_BITS-1:0]   shift;
  } mode_cfg_t;

endpackage

// ===== rtl/rhfs_queue.sv =====
`include "ripple_height_field_stencil_core_assert.svh"

module rhfs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rhfs_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH+1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;

  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `RHFS_ASSERT_NOW(a_queue_no_overflow, push && !pop, count != CNT_BITS'(DEPTH), "queue overflow")
  `RHFS_ASSERT_NOW(a_queue_no_underflow, pop, count != '0, "queue underflow")

endmodule

// ===== rtl/rhfs_front.sv =====
`include "ripple_height_field_stencil_core_assert.svh"

module rhfs_front #(
  parameter int MAX_WIDTH   = rhfs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = rhfs_pkg::DEF_MAX_HEIGHT,
  parameter int HEIGHT_BITS = rhfs_pkg::DEF_HEIGHT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic signed [HEIGHT_BITS-1:0]       old_height,
  input  logic signed [HEIGHT_BITS-1:0]       prev_height,
  input  logic                                frame_start,
  input  logic [$clog2(MAX_WIDTH):0]          wdim,
  input  logic [$clog2(MAX_HEIGHT):0]         hdim,
  output logic                                q_push,
  output rhfs_pkg::flags_t                    q_flags,
  output logic [$clog2(MAX_HEIGHT)-1:0]       q_row,
  output logic [$clog2(MAX_WIDTH)-1:0]        q_col,
  output logic signed [HEIGHT_BITS+2:0]       q_sum,
  output logic signed [HEIGHT_BITS-1:0]       q_dprev,
  output logic signed [HEIGHT_BITS-1:0]       q_prev
);
  import rhfs_pkg::*;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int ROW_BITS = $clog2(MAX_HEIGHT);
  localparam int SW       = HEIGHT_BITS + 3;
  localparam int DDEPTH   = MAX_WIDTH + 1;
  localparam int DP_BITS  = $clog2(DDEPTH);
  localparam int DPX      = DP_BITS + 1;

  // position counters
  logic [COL_BITS-1:0] col;
  logic [ROW_BITS-1:0] row;
  logic [COL_BITS-1:0] col_next;
  logic [ROW_BITS-1:0] row_next;
  logic [COL_BITS-1:0] c_cur;
  logic [ROW_BITS:0]   r_tmp;
  logic [ROW_BITS-1:0] r_cur;
  logic [COL_BITS:0]   c_inc;
  logic [ROW_BITS:0]   r_inc;
  flags_t              flags_cur;

  // stores
  logic signed [HEIGHT_BITS-1:0] bank0 [MAX_WIDTH];
  logic signed [HEIGHT_BITS-1:0] bank1 [MAX_WIDTH];
  logic signed [HEIGHT_BITS-1:0] dline [DDEPTH];
  logic signed [HEIGHT_BITS-1:0] rd0;
  logic signed [HEIGHT_BITS-1:0] rd1;
  logic [DP_BITS-1:0]            wp;
  logic [DP_BITS-1:0]            rd_ptr;
  logic [DPX-1:0]                lag;

  // second stage
  logic                          f1_valid;
  flags_t                        f1_flags;
  logic [ROW_BITS-1:0]           f1_row;
  logic [COL_BITS-1:0]           f1_col;
  logic                          f1_slot;
  logic signed [HEIGHT_BITS-1:0] f1_old;
  logic signed [HEIGHT_BITS-1:0] f1_prev;
  logic signed [HEIGHT_BITS-1:0] top_v;
  logic signed [HEIGHT_BITS-1:0] mid_v;

  // window columns 1 and 2; column 0 is never needed after the sum
  logic signed [HEIGHT_BITS-1:0] wa [3];
  logic signed [HEIGHT_BITS-1:0] wb [3];

  // fold counters against the current size, then classify
  always_comb begin
    c_cur = frame_start ? '0 : col;
    r_tmp = frame_start ? '0 : {1'b0, row};
    if ({1'b0, c_cur} >= wdim) begin
      c_cur = '0;
      r_tmp = r_tmp + 1'b1;
    end
    if (r_tmp >= hdim) begin
      r_tmp = '0;
    end
    r_cur = r_tmp[ROW_BITS-1:0];

    flags_cur.has_int  = (r_cur >= ROW_BITS'(2)) && (c_cur >= COL_BITS'(2));
    flags_cur.has_bord = (r_cur == '0) || ({1'b0, r_cur} == hdim - 1'b1) ||
                         (c_cur == '0) || ({1'b0, c_cur} == wdim - 1'b1);

    c_inc = {1'b0, c_cur} + 1'b1;
    r_inc = {1'b0, r_cur} + 1'b1;
    if (c_inc >= wdim) begin
      col_next = '0;
      row_next = (r_inc >= hdim) ? '0 : r_inc[ROW_BITS-1:0];
    end else begin
      col_next = c_inc[COL_BITS-1:0];
      row_next = r_cur;
    end
  end

  // prev is read back width+1 cells later
  always_comb begin
    lag = DPX'(wdim) + DPX'(1);
    if ({1'b0, wp} >= lag) begin
      rd_ptr = DP_BITS'({1'b0, wp} - lag);
    end else begin
      rd_ptr = DP_BITS'({1'b0, wp} + DPX'(DDEPTH) - lag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      wp  <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
      wp  <= (wp == DP_BITS'(DDEPTH-1)) ? '0 : wp + 1'b1;
    end
  end

  // read-first: an entry read and written in the same cycle returns the old value
  always_ff @(posedge clk) begin
    if (accept) begin
      rd0 <= bank0[c_cur];
      rd1 <= bank1[c_cur];
      if (!r_cur[0]) begin
        bank0[c_cur] <= old_height;
      end else begin
        bank1[c_cur] <= old_height;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_dprev     <= dline[rd_ptr];
      dline[wp]   <= prev_height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_flags <= flags_cur;
      f1_row   <= r_cur;
      f1_col   <= c_cur;
      f1_slot  <= r_cur[0];
      f1_old   <= old_height;
      f1_prev  <= prev_height;
    end
  end

  // slot of an odd row holds row r-2 in bank1
  assign top_v = f1_slot ? rd1 : rd0;
  assign mid_v = f1_slot ? rd0 : rd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        wa[k] <= '0;
        wb[k] <= '0;
      end
    end else if (f1_valid) begin
      for (int k = 0; k < 3; k++) begin
        wa[k] <= wb[k];
      end
      wb[0] <= top_v;
      wb[1] <= mid_v;
      wb[2] <= f1_old;
    end
  end

  // eight neighbours; centre is wb[1]
  assign q_sum = SW'(wa[0]) + SW'(wb[0]) + SW'(top_v) +
                 SW'(wa[1]) + SW'(mid_v) +
                 SW'(wa[2]) + SW'(wb[2]) + SW'(f1_old);

  // cells with no result only update the stores and window
  assign q_push  = f1_valid && (f1_flags.has_int || f1_flags.has_bord);
  assign q_flags = f1_flags;
  assign q_row   = f1_row;
  assign q_col   = f1_col;
  assign q_prev  = f1_prev;

  `RHFS_ASSERT_NEXT(a_frame_origin, accept && frame_start, f1_row == '0 && f1_col == '0, "frame start not at origin")

endmodule

// ===== rtl/rhfs_back.sv =====
`include "ripple_height_field_stencil_core_assert.svh"

module rhfs_back #(
  parameter int MAX_WIDTH   = rhfs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = rhfs_pkg::DEF_MAX_HEIGHT,
  parameter int HEIGHT_BITS = rhfs_pkg::DEF_HEIGHT_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  rhfs_pkg::flags_t                q_flags,
  input  logic [$clog2(MAX_HEIGHT)-1:0]   q_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]    q_col,
  input  logic signed [HEIGHT_BITS+2:0]   q_sum,
  input  logic signed [HEIGHT_BITS-1:0]   q_dprev,
  input  logic signed [HEIGHT_BITS-1:0]   q_prev,
  input  logic [$clog2(MAX_WIDTH):0]      wdim,
  input  rhfs_pkg::mode_cfg_t             mode_cfg,
  input  logic                            pop,
  output logic                            empty,
  output logic signed [HEIGHT_BITS-1:0]   new_height,
  output logic [rhfs_pkg::IDX_BITS-1:0]   cell_index,
  output logic                            last_of_item
);
  import rhfs_pkg::*;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int ROW_BITS = $clog2(MAX_HEIGHT);
  localparam int W_BITS   = COL_BITS + 1;
  localparam int VW       = HEIGHT_BITS + 3;
  localparam logic signed [VW-1:0] SAT_HI = (VW'(1) <<< (HEIGHT_BITS-1)) - VW'(1);
  localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);

  // execute stage
  logic                          e_valid;
  logic                          e_ready;
  flags_t                        e_flags;
  logic signed [VW-1:0]          e_v1;
  logic [IDX_BITS-1:0]           e_prod;
  logic [COL_BITS-1:0]           e_col;
  logic signed [HEIGHT_BITS-1:0] e_prev;
  logic signed [VW-1:0]          v1_next;
  logic [ROW_BITS+W_BITS-1:0]    prod_full;

  // result register, up to two results per cell
  logic                          o_int_pend;
  logic                          o_bord_pend;
  logic                          o_free;
  logic signed [HEIGHT_BITS-1:0] o_int_val;
  logic signed [HEIGHT_BITS-1:0] o_bord_val;
  logic [IDX_BITS-1:0]           o_int_idx;
  logic [IDX_BITS-1:0]           o_bord_idx;
  logic signed [VW-1:0]          damp;
  logic signed [VW-1:0]          fin;
  logic signed [HEIGHT_BITS-1:0] sat_v;
  logic [IDX_BITS-1:0]           bidx;
  logic [IDX_BITS-1:0]           iidx;

  always_comb begin
    if (mode_cfg.mode == MODE_RIPPLE) begin
      v1_next = (q_sum >>> RIPPLE_SHIFT) - VW'(q_dprev);
    end else begin
      v1_next = ((q_sum >>> SMOOTH_SHIFT) + VW'(q_dprev)) >>> 1;
    end
  end

  assign prod_full = q_row * wdim;

  assign e_ready = !e_valid || o_free;
  assign q_pop   = q_valid && e_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_ready) begin
      e_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      e_flags <= q_flags;
      e_v1    <= v1_next;
      e_prod  <= IDX_BITS'(prod_full);
      e_col   <= q_col;
      e_prev  <= q_prev;
    end
  end

  // damping (ripple mode only), saturation and both indices
  always_comb begin
    damp = e_v1 - (e_v1 >>> mode_cfg.shift);
    fin  = (mode_cfg.mode == MODE_RIPPLE) ? damp : e_v1;
    if (fin > SAT_HI) begin
      sat_v = SAT_HI[HEIGHT_BITS-1:0];
    end else if (fin < SAT_LO) begin
      sat_v = SAT_LO[HEIGHT_BITS-1:0];
    end else begin
      sat_v = fin[HEIGHT_BITS-1:0];
    end
    bidx = e_prod + IDX_BITS'(e_col);
    iidx = bidx - IDX_BITS'(wdim) - IDX_BITS'(1);
  end

  assign empty        = !(o_int_pend || o_bord_pend);
  assign last_of_item = !(o_int_pend && o_bord_pend);
  assign new_height   = o_int_pend ? o_int_val : o_bord_val;
  assign cell_index   = o_int_pend ? o_int_idx : o_bord_idx;
  assign o_free       = empty || (pop && last_of_item);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_int_pend  <= 1'b0;
      o_bord_pend <= 1'b0;
    end else if (o_free) begin
      o_int_pend  <= e_valid && e_flags.has_int;
      o_bord_pend <= e_valid && e_flags.has_bord;
    end else if (pop) begin
      // interior result taken, border result follows
      o_int_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && e_valid) begin
      o_int_val  <= sat_v;
      o_bord_val <= e_prev;
      o_int_idx  <= iidx;
      o_bord_idx <= bidx;
    end
  end

  `RHFS_ASSERT_NEXT(a_second_result_follows, pop && !empty && !last_of_item, !empty && last_of_item, "second result of a cell lost")

endmodule

// ===== rtl/ripple_height_field_stencil_core.sv =====
// Ripple / smoothing height-field stencil. Cells of the old field and of the field two
// steps back arrive in raster order, one request per clock when the result side keeps
// up; each cell yields zero, one or two results (an interior result for the cell up
// and to the left once its 3x3 window is complete, then a border pass-through), and
// the result port delivers one per clock while pop is held; only cells in the last
// column from row 2 on and cells in the last row from column 2 on yield a second
// result. In the path of a result, the line-store and delay-line reads are registered
// at the edge that accepts its cell, the window sum is then written into the short
// queue, and the value passes one execute stage and the result register. The two row
// stores (2 x MAX_WIDTH) and the prev delay line (MAX_WIDTH+1) are not cleared;
// results that would read never-written entries are undefined. frame_start puts a
// cell at row 0, column 0. The user must write registers only while the block is
// idle; the block does not enforce this.
`include "ripple_height_field_stencil_core_assert.svh"

module ripple_height_field_stencil_core #(
  parameter int MAX_WIDTH   = rhfs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = rhfs_pkg::DEF_MAX_HEIGHT,
  parameter int HEIGHT_BITS = rhfs_pkg::DEF_HEIGHT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic signed [HEIGHT_BITS-1:0]  old_height,
  input  logic signed [HEIGHT_BITS-1:0]  prev_height,
  input  logic                           frame_start,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [HEIGHT_BITS-1:0]  new_height,
  output logic [rhfs_pkg::IDX_BITS-1:0]  cell_index,
  output logic                           last_of_item,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [rhfs_pkg::CFG_BITS-1:0]  cfg_data
);
  import rhfs_pkg::*;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int ROW_BITS = $clog2(MAX_HEIGHT);
  localparam int W_BITS   = COL_BITS + 1;
  localparam int H_BITS   = ROW_BITS + 1;
  localparam int SW       = HEIGHT_BITS + 3;
  localparam int E_BITS   = 2 + ROW_BITS + COL_BITS + SW + 2 * HEIGHT_BITS;
  localparam int QC_BITS  = $clog2(QUEUE_DEPTH + 1);

  logic [CFG_BITS-1:0]   field_width;
  logic [CFG_BITS-1:0]   field_height;
  logic [SHIFT_BITS-1:0] damping_shift;
  update_mode_t          update_mode;
  mode_cfg_t             mode_cfg;
  logic [W_BITS-1:0]     wdim;
  logic [H_BITS-1:0]     hdim;

  logic                          accept;
  logic                          f_push;
  flags_t                        f_flags;
  logic [ROW_BITS-1:0]           f_row;
  logic [COL_BITS-1:0]           f_col;
  logic signed [SW-1:0]          f_sum;
  logic signed [HEIGHT_BITS-1:0] f_dprev;
  logic signed [HEIGHT_BITS-1:0] f_prev;

  logic [E_BITS-1:0]             q_din;
  logic [E_BITS-1:0]             q_dout;
  logic [QC_BITS-1:0]            q_count;
  logic [QC_BITS:0]              q_load;
  logic                          q_pop;
  flags_t                        b_flags;
  logic [ROW_BITS-1:0]           b_row;
  logic [COL_BITS-1:0]           b_col;
  logic signed [SW-1:0]          b_sum;
  logic signed [HEIGHT_BITS-1:0] b_dprev;
  logic signed [HEIGHT_BITS-1:0] b_prev;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_width   <= RST_FIELD_WIDTH;
      field_height  <= RST_FIELD_HEIGHT;
      damping_shift <= RST_DAMPING_SHIFT;
      update_mode   <= MODE_RIPPLE;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_FIELD_WIDTH:   field_width   <= cfg_data;
        REG_FIELD_HEIGHT:  field_height  <= cfg_data;
        REG_DAMPING_SHIFT: damping_shift <= cfg_data[SHIFT_BITS-1:0];
        REG_UPDATE_MODE:   update_mode   <= update_mode_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  // size as used: clamped to [3, MAX]
  always_comb begin
    if (int'(field_width) < MIN_DIM) begin
      wdim = W_BITS'(MIN_DIM);
    end else if (int'(field_width) > MAX_WIDTH) begin
      wdim = W_BITS'(MAX_WIDTH);
    end else begin
      wdim = W_BITS'(field_width);
    end
    if (int'(field_height) < MIN_DIM) begin
      hdim = H_BITS'(MIN_DIM);
    end else if (int'(field_height) > MAX_HEIGHT) begin
      hdim = H_BITS'(MAX_HEIGHT);
    end else begin
      hdim = H_BITS'(field_height);
    end
  end

  assign mode_cfg.mode  = update_mode;
  assign mode_cfg.shift = damping_shift;

  // credit: room for what sits in the second front stage plus this request
  assign q_load = (QC_BITS+1)'(q_count) + (QC_BITS+1)'(f_push);
  assign full   = rst || (q_load >= (QC_BITS+1)'(QUEUE_DEPTH));
  assign accept = push && !full;

  rhfs_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .old_height  (old_height),
    .prev_height (prev_height),
    .frame_start (frame_start),
    .wdim        (wdim),
    .hdim        (hdim),
    .q_push      (f_push),
    .q_flags     (f_flags),
    .q_row       (f_row),
    .q_col       (f_col),
    .q_sum       (f_sum),
    .q_dprev     (f_dprev),
    .q_prev      (f_prev)
  );

  assign q_din = {f_flags, f_row, f_col, f_sum, f_dprev, f_prev};
  assign {b_flags, b_row, b_col, b_sum, b_dprev, b_prev} = q_dout;

  rhfs_queue #(
    .WIDTH (E_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .count (q_count)
  );

  rhfs_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_count != '0),
    .q_pop        (q_pop),
    .q_flags      (b_flags),
    .q_row        (b_row),
    .q_col        (b_col),
    .q_sum        (b_sum),
    .q_dprev      (b_dprev),
    .q_prev       (b_prev),
    .wdim         (wdim),
    .mode_cfg     (mode_cfg),
    .pop          (pop),
    .empty        (empty),
    .new_height   (new_height),
    .cell_index   (cell_index),
    .last_of_item (last_of_item)
  );

endmodule

// ===== sim/ripple_height_field_stencil_core_tb.sv =====
module ripple_height_field_stencil_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rhfs_pkg::*;

  localparam int unsigned MAXW  = DEF_MAX_WIDTH;
  localparam int unsigned MAXH  = DEF_MAX_HEIGHT;
  localparam int unsigned DEPTH = MAXW + 1;

  typedef struct {
    logic signed [DEF_HEIGHT_BITS-1:0] height;
    logic [IDX_BITS-1:0]               index;
    logic                              last;
  } height_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [DEF_HEIGHT_BITS-1:0] old_height = '0;
  logic signed [DEF_HEIGHT_BITS-1:0] prev_height = '0;
  logic frame_start = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [DEF_HEIGHT_BITS-1:0] new_height;
  logic [IDX_BITS-1:0] cell_index;
  logic last_of_item;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_FIELD_WIDTH;
  logic [CFG_BITS-1:0] cfg_data = '0;

  // stencil state as the block should hold it
  logic signed [DEF_HEIGHT_BITS-1:0] row_mem [2*MAXW];
  logic signed [DEF_HEIGHT_BITS-1:0] prev_line [DEPTH];
  logic signed [DEF_HEIGHT_BITS-1:0] win [3][3];
  int unsigned col_pos, row_pos, line_wp;
  logic [CFG_BITS-1:0] cfg_width = RST_FIELD_WIDTH;
  logic [CFG_BITS-1:0] cfg_height = RST_FIELD_HEIGHT;
  logic [SHIFT_BITS-1:0] cfg_shift = RST_DAMPING_SHIFT;
  update_mode_t cfg_mode = MODE_RIPPLE;

  height_result_t pending_heights [$];

  int unsigned cells_sent, results_seen, settings_used, mismatches;
  int unsigned burst_left, stall_tick;
  int unsigned stall_mode;

  ripple_height_field_stencil_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .old_height(old_height), .prev_height(prev_height), .frame_start(frame_start),
    .empty(empty), .pop(pop), .new_height(new_height), .cell_index(cell_index),
    .last_of_item(last_of_item), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned clamp_dim(input logic [CFG_BITS-1:0] v,
                                            input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic logic signed [DEF_HEIGHT_BITS-1:0] clip_height(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[DEF_HEIGHT_BITS-1:0];
  endfunction

  function automatic logic signed [DEF_HEIGHT_BITS-1:0] pick_height();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic predict_heights(input logic signed [DEF_HEIGHT_BITS-1:0] oh,
                                 input logic signed [DEF_HEIGHT_BITS-1:0] ph,
                                 input logic fs);
    int unsigned w, h, r, c, slot, rd;
    int k, j;
    logic signed [DEF_HEIGHT_BITS-1:0] top, mid, dprev;
    longint sum, v;
    height_result_t res;
    bit interior, border;
    w = clamp_dim(cfg_width, MAXW);
    h = clamp_dim(cfg_height, MAXH);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    // counters left outside a smaller field are folded back in
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;

    slot = r & 1;
    top = row_mem[slot*MAXW + c];
    mid = row_mem[(slot^1)*MAXW + c];
    row_mem[slot*MAXW + c] = oh;
    for (k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = oh;

    rd = (line_wp + DEPTH - (w + 1)) % DEPTH;
    dprev = prev_line[rd];
    prev_line[line_wp] = ph;
    line_wp = (line_wp + 1) % DEPTH;

    interior = (r >= 2 && c >= 2);
    border = (r == 0 || r == h - 1 || c == 0 || c == w - 1);
    if (interior) begin
      sum = 0;
      for (k = 0; k < 3; k++)
        for (j = 0; j < 3; j++)
          if (!(k == 1 && j == 1)) sum = sum + win[k][j];
      if (cfg_mode == MODE_RIPPLE) begin
        v = (sum >>> RIPPLE_SHIFT) - dprev;
        v = v - (v >>> cfg_shift);
      end else begin
        v = ((sum >>> SMOOTH_SHIFT) + dprev) >>> 1;
      end
      res.height = clip_height(v);
      res.index = IDX_BITS'((r - 1) * w + (c - 1));
      res.last = !border;
      pending_heights.push_back(res);
    end
    if (border) begin
      res.height = ph;
      res.index = IDX_BITS'(r * w + c);
      res.last = 1'b1;
      pending_heights.push_back(res);
    end

    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // one request per call; push stays high afterwards unless a gap is taken
  task automatic send_cell(input logic signed [DEF_HEIGHT_BITS-1:0] oh,
                           input logic signed [DEF_HEIGHT_BITS-1:0] ph,
                           input logic fs);
    old_height <= oh;
    prev_height <= ph;
    frame_start <= fs;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_heights(oh, ph, fs);
    cells_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    // cells with no result may still be in flight
    repeat (12) @(posedge clk);
  endtask

  task automatic program_field(input logic [CFG_BITS-1:0] wr_w,
                               input logic [CFG_BITS-1:0] wr_h,
                               input logic [SHIFT_BITS-1:0] shift,
                               input update_mode_t mode);
    logic [CFG_BITS-1:0] junk;
    junk = CFG_BITS'($urandom);
    cfg_we <= 1'b1;
    cfg_index <= REG_FIELD_WIDTH;
    cfg_data <= wr_w;
    @(posedge clk);
    cfg_index <= REG_FIELD_HEIGHT;
    cfg_data <= wr_h;
    @(posedge clk);
    cfg_index <= REG_DAMPING_SHIFT;
    cfg_data <= {junk[CFG_BITS-1:SHIFT_BITS], shift};
    @(posedge clk);
    cfg_index <= REG_UPDATE_MODE;
    cfg_data <= {junk[CFG_BITS-1:1], mode};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_width = wr_w;
    cfg_height = wr_h;
    cfg_shift = shift;
    cfg_mode = mode;
    settings_used++;
  endtask

  task automatic check_height();
    height_result_t want;
    if (pending_heights.size() == 0) begin
      flag_error($sformatf("result with nothing pending, index %0d", cell_index));
      return;
    end
    want = pending_heights.pop_front();
    results_seen++;
    if (new_height !== want.height)
      flag_error($sformatf("cell %0d new_height %0d, want %0d",
                           want.index, new_height, want.height));
    if (cell_index !== want.index)
      flag_error($sformatf("cell_index %0d, want %0d", cell_index, want.index));
    if (last_of_item !== want.last)
      flag_error($sformatf("cell %0d last_of_item %b, want %b",
                           want.index, last_of_item, want.last));
  endtask

  // result side: pop follows a stall pattern that is redrawn at random
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_height();
      stall_tick++;
      if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= stall_tick[3];
      endcase
    end
  end

  // 3x3 fields driven into saturation both ways; second field reached by wrap
  task automatic test_saturation();
    int i;
    program_field(11'd0, 11'd1, 4'd15, MODE_RIPPLE);
    for (i = 0; i < 9; i++) send_cell(16'sh7FFF, 16'sh8000, i == 0);
    for (i = 0; i < 9; i++) send_cell(16'sh8000, 16'sh7FFF, 1'b0);
    settle();
  endtask

  task automatic test_smooth_restart();
    int i;
    program_field(11'd3, 11'd3, 4'd0, MODE_SMOOTH);
    send_cell(16'sh7FFF, 16'sh8000, 1'b1);
    send_cell(16'sh8000, 16'sh7FFF, 1'b0);
    for (i = 0; i < 9; i++)
      send_cell(i[0] ? 16'sh8000 : 16'sh7FFF, (i > 4) ? 16'sh8000 : 16'sh7FFF, i == 0);
    settle();
  endtask

  // shrink width then height part-way through a field
  task automatic test_fold_mid_field();
    int i;
    program_field(11'd20, 11'd6, 4'd3, MODE_RIPPLE);
    for (i = 0; i < 55; i++) send_cell(pick_height(), pick_height(), i == 0);
    settle();
    program_field(11'd12, 11'd6, 4'd1, MODE_SMOOTH);
    for (i = 0; i < 24; i++) send_cell(pick_height(), pick_height(), 1'b0);
    settle();
    program_field(11'd12, 11'd4, 4'd7, MODE_RIPPLE);
    for (i = 0; i < 40; i++) send_cell(pick_height(), pick_height(), 1'b0);
    settle();
  endtask

  // widest row and its wrap into the next; then a clamped height past the third row
  task automatic test_largest_sizes();
    int i;
    program_field(11'h7FF, 11'd3, SHIFT_BITS'($urandom), MODE_RIPPLE);
    for (i = 0; i < 1028; i++) send_cell(pick_height(), pick_height(), i == 0);
    settle();
    program_field(11'd3, 11'h7FF, SHIFT_BITS'($urandom), MODE_SMOOTH);
    for (i = 0; i < 30; i++) send_cell(pick_height(), pick_height(), i == 0);
    settle();
  endtask

  task automatic test_random_fields();
    logic [CFG_BITS-1:0] rw, rh;
    int unsigned w, h, start, nf, cells, f, i;
    bit noisy, lead_fs;
    start = cells_sent;
    while (cells_sent - start < 150) begin
      rw = CFG_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                  : $urandom_range(3, 14));
      rh = CFG_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                  : $urandom_range(3, 8));
      program_field(rw, rh, SHIFT_BITS'($urandom),
                    update_mode_t'($urandom_range(0, 1)));
      w = clamp_dim(rw, MAXW);
      h = clamp_dim(rh, MAXH);
      nf = $urandom_range(1, 3);
      for (f = 0; f < nf; f++) begin
        cells = w * h;
        noisy = 1'b0;
        case ($urandom_range(0, 9))
          0: cells = $urandom_range(1, cells - 1);
          1: noisy = 1'b1;
          default: ;
        endcase
        // a new width must start clean; later fields may lean on wrap-around
        lead_fs = (f == 0) || ($urandom_range(0, 2) != 0);
        for (i = 0; i < cells; i++)
          send_cell(pick_height(), pick_height(),
                    (i == 0 && lead_fs) || (noisy && $urandom_range(0, 11) == 0));
      end
      settle();
    end
  endtask

  initial begin
    foreach (row_mem[i]) row_mem[i] = '0;
    foreach (prev_line[i]) prev_line[i] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    col_pos = 0;
    row_pos = 0;
    line_wp = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_saturation();
    test_smooth_restart();
    test_fold_mid_field();
    test_largest_sizes();
    test_random_fields();
    settle();
    $display("Sent %0d cells, checked %0d results under %0d register settings",
             cells_sent, results_seen, settings_used);
    $display("Both modes, saturation, rows 3 to 1024 wide, size clamping, restarts, folding");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
